// File: src/spq_pkg.sv
// Shared types and constants for the three-level strict priority queue.
package spq_pkg;

  localparam int NumLevels   = 3;
  localparam int LevelW      = 2;
  localparam int IdFieldW    = 16;
  localparam int OccFieldW   = 8;
  localparam int TotalW      = 16;
  localparam int FifoDepthDef = 128;
  localparam int IdWidthDef   = 16;

  typedef enum logic {
    OpInsert = 1'b0,
    OpServe  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatFull     = 2'd1,
    StatBadLevel = 2'd2,
    StatEmpty    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CsIdle,
    CsExec,
    CsFinish
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic finish;
  } cmd_t;

endpackage

// File: src/spq_ctrl.sv
// Sequencing state machine for the priority queue.
module spq_ctrl
  import spq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CsIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      CsIdle: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = CsExec;
        end
      end
      CsExec: begin
        cmd_o.exec = 1'b1;
        state_d    = CsFinish;
      end
      CsFinish: begin
        cmd_o.finish = 1'b1;
        state_d      = CsIdle;
      end
      default: begin
        state_d = CsIdle;
      end
    endcase
  end

  assign busy_o = (state_q != CsIdle);

endmodule

// File: src/spq_datapath.sv
// Entry store, per-level pointers and counters, and result registers.
module spq_datapath
  import spq_pkg::*;
#(
  parameter int FIFO_DEPTH = FifoDepthDef,
  parameter int ID_WIDTH   = IdWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  logic                 opcode_i,
  input  logic [IdFieldW-1:0]  item_id_i,
  input  logic [LevelW-1:0]    level_i,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic                 served_valid_o,
  output logic [IdFieldW-1:0]  served_id_o,
  output logic [OccFieldW-1:0] occupancy_high_o,
  output logic [OccFieldW-1:0] occupancy_mid_o,
  output logic [OccFieldW-1:0] occupancy_low_o,
  output logic [TotalW-1:0]    served_total_o
);

  localparam int StoreW = (ID_WIDTH < IdFieldW) ? ID_WIDTH : IdFieldW;
  localparam int PtrW   = $clog2(FIFO_DEPTH);
  localparam int CntW   = $clog2(FIFO_DEPTH + 1);
  localparam int OccW   = (CntW < OccFieldW) ? CntW : OccFieldW;

  localparam logic [PtrW-1:0] LastSlot = PtrW'(FIFO_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(FIFO_DEPTH);

  // Captured item
  op_e               op_q;
  logic [StoreW-1:0] id_q;
  logic [LevelW-1:0] lvl_q;

  // Queue state
  logic [PtrW-1:0]   head_q [NumLevels];
  logic [PtrW-1:0]   tail_q [NumLevels];
  logic [CntW-1:0]   cnt_q  [NumLevels];
  logic [TotalW-1:0] total_q;

  logic [StoreW-1:0] mem_q [NumLevels][FIFO_DEPTH];
  logic [StoreW-1:0] rd_data_q;

  // Outcome of the execute cycle
  status_e     stat_q;
  logic        valid_q;

  // Result registers
  logic                 done_q;
  status_e              res_stat_q;
  logic                 res_valid_q;
  logic [IdFieldW-1:0]  res_id_q;
  logic [OccFieldW-1:0] res_occ_q [NumLevels];
  logic [TotalW-1:0]    res_total_q;

  logic [LevelW-1:0] sel;
  logic              do_wr, do_rd;
  status_e           stat_d;
  logic [IdFieldW-1:0]  id_ext;
  logic [OccFieldW-1:0] occ_ext [NumLevels];

  // Pick the level and decide the outcome.
  always_comb begin
    sel    = '0;
    do_wr  = 1'b0;
    do_rd  = 1'b0;
    stat_d = StatOk;
    unique case (op_q)
      OpInsert: begin
        if (lvl_q == '0) begin
          stat_d = StatBadLevel;
        end else begin
          sel = lvl_q - LevelW'(1);
          if (cnt_q[sel] == FullCnt) begin
            stat_d = StatFull;
          end else begin
            do_wr = 1'b1;
          end
        end
      end
      OpServe: begin
        priority if (cnt_q[0] != '0) begin
          sel   = LevelW'(0);
          do_rd = 1'b1;
        end else if (cnt_q[1] != '0) begin
          sel   = LevelW'(1);
          do_rd = 1'b1;
        end else if (cnt_q[2] != '0) begin
          sel   = LevelW'(2);
          do_rd = 1'b1;
        end else begin
          stat_d = StatEmpty;
        end
      end
      default: begin
        stat_d = StatOk;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_e'(opcode_i);
      id_q  <= item_id_i[StoreW-1:0];
      lvl_q <= level_i;
    end
    if (cmd_i.exec) begin
      stat_q  <= stat_d;
      valid_q <= do_rd;
    end
  end

  // Entry store: at most one write or one registered read per item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && do_wr) begin
      mem_q[sel][tail_q[sel]] <= id_q;
    end
    if (cmd_i.exec && do_rd) begin
      rd_data_q <= mem_q[sel][head_q[sel]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLevels; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      total_q <= '0;
    end else if (cmd_i.exec) begin
      if (do_wr) begin
        tail_q[sel] <= (tail_q[sel] == LastSlot) ? '0 : tail_q[sel] + PtrW'(1);
        cnt_q[sel]  <= cnt_q[sel] + CntW'(1);
      end
      if (do_rd) begin
        head_q[sel] <= (head_q[sel] == LastSlot) ? '0 : head_q[sel] + PtrW'(1);
        cnt_q[sel]  <= cnt_q[sel] - CntW'(1);
        if (total_q != '1) begin
          total_q <= total_q + TotalW'(1);
        end
      end
    end
  end

  always_comb begin
    id_ext = '0;
    if (valid_q) begin
      id_ext[StoreW-1:0] = rd_data_q;
    end
    for (int i = 0; i < NumLevels; i++) begin
      occ_ext[i]           = '0;
      occ_ext[i][OccW-1:0] = cnt_q[i][OccW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_stat_q  <= stat_q;
      res_valid_q <= valid_q;
      res_id_q    <= id_ext;
      for (int i = 0; i < NumLevels; i++) begin
        res_occ_q[i] <= occ_ext[i];
      end
      res_total_q <= total_q;
    end
  end

  assign done_o           = done_q;
  assign status_o         = res_stat_q;
  assign served_valid_o   = res_valid_q;
  assign served_id_o      = res_id_q;
  assign occupancy_high_o = res_occ_q[0];
  assign occupancy_mid_o  = res_occ_q[1];
  assign occupancy_low_o  = res_occ_q[2];
  assign served_total_o   = res_total_q;

endmodule

// File: src/three_level_strict_priority_queue.sv
// Top level of the three-level strict priority queue.
//
//   Channel   Handshake          Payload
//   command   start_i / busy_o   opcode_i, item_id_i, level_i
//   result    done_o (strobe)    status_o, served_valid_o, served_id_o,
//                                occupancy_{high,mid,low}_o, served_total_o
//
// Each item passes through accept, execute (pointer and counter update plus
// at most one access to the entry store), then load of the result registers.
// The result strobe follows in the next cycle, in the same cycle in which the
// next item may already be accepted. The entry store has a registered read
// port, read in the execute step. Reset clears pointers, counts and the served
// total; the entry store is not cleared. The receiver cannot stall: the strobe
// is shown for exactly one cycle and the payload is held until the next result.
module three_level_strict_priority_queue
  import spq_pkg::*;
#(
  parameter int FIFO_DEPTH = FifoDepthDef,
  parameter int ID_WIDTH   = IdWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 opcode_i,
  input  logic [IdFieldW-1:0]  item_id_i,
  input  logic [LevelW-1:0]    level_i,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic                 served_valid_o,
  output logic [IdFieldW-1:0]  served_id_o,
  output logic [OccFieldW-1:0] occupancy_high_o,
  output logic [OccFieldW-1:0] occupancy_mid_o,
  output logic [OccFieldW-1:0] occupancy_low_o,
  output logic [TotalW-1:0]    served_total_o
);

  cmd_t cmd;

  // Sequence each item through capture, execute and finish.
  spq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  // Hold the FIFOs and build the result.
  spq_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .ID_WIDTH   (ID_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .opcode_i         (opcode_i),
    .item_id_i        (item_id_i),
    .level_i          (level_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .served_valid_o   (served_valid_o),
    .served_id_o      (served_id_o),
    .occupancy_high_o (occupancy_high_o),
    .occupancy_mid_o  (occupancy_mid_o),
    .occupancy_low_o  (occupancy_low_o),
    .served_total_o   (served_total_o)
  );

endmodule
